### hdl/psc_pkg.sv
// Shared types and constants for the pressure sensor compensation pipeline
package psc_pkg;

  // APB register map: register index is paddr[4:2]
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // correction band codes
  localparam logic [1:0] BAND_NONE  = 2'd0;
  localparam logic [1:0] BAND_COLD  = 2'd1;
  localparam logic [1:0] BAND_FROST = 2'd2;

  // register stages from accepted start to result strobe
  localparam int unsigned PipeLatency = 11;

  // internal widths
  localparam int unsigned DtW   = 25;
  localparam int unsigned TempW = 20;
  localparam int unsigned T2W   = 18;
  localparam int unsigned OffW  = 40;
  localparam int unsigned SensW = 39;
  localparam int unsigned ToutW = 19;
  localparam int unsigned PresW = 27;

  // temperature thresholds (first-order TEMP, 0.01 degC)
  localparam logic signed [TempW-1:0] TempRef   = 20'sd2000;
  localparam logic signed [TempW-1:0] TempFrost = -20'sd1500;

  // same thresholds at output width
  localparam logic signed [ToutW-1:0] ToutRef   = 19'sd2000;
  localparam logic signed [ToutW-1:0] ToutFrost = -19'sd1500;

  // saturation limits
  localparam logic signed [ToutW-1:0] ToutMax = 19'sd262143;
  localparam logic signed [ToutW-1:0] ToutMin = -19'sd262144;
  localparam logic signed [PresW-1:0] PresMax = 27'sd67108863;
  localparam logic signed [PresW-1:0] PresMin = -27'sd67108864;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } coef_t;

  // first-order results
  typedef struct packed {
    logic [23:0]              d1;
    logic signed [TempW-1:0]  temp;
    logic [T2W-1:0]           t2;
    logic signed [OffW-1:0]   off;
    logic signed [SensW-1:0]  sens;
  } first_t;

  // second-order corrected results
  typedef struct packed {
    logic [23:0]              d1;
    logic signed [OffW-1:0]   off;
    logic signed [SensW-1:0]  sens;
    logic signed [ToutW-1:0]  tout;
    logic [1:0]               band;
  } second_t;

endpackage

### hdl/psc_regs.sv
// Calibration coefficient registers behind an APB port
module psc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [psc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output psc_pkg::coef_t             coef_o
);

  psc_pkg::coef_t coef_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes, indexes above C6 ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        psc_pkg::REG_C1: coef_q.c1 <= pwdata[15:0];
        psc_pkg::REG_C2: coef_q.c2 <= pwdata[15:0];
        psc_pkg::REG_C3: coef_q.c3 <= pwdata[15:0];
        psc_pkg::REG_C4: coef_q.c4 <= pwdata[15:0];
        psc_pkg::REG_C5: coef_q.c5 <= pwdata[15:0];
        psc_pkg::REG_C6: coef_q.c6 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[4:2])
      psc_pkg::REG_C1: prdata = {16'h0000, coef_q.c1};
      psc_pkg::REG_C2: prdata = {16'h0000, coef_q.c2};
      psc_pkg::REG_C3: prdata = {16'h0000, coef_q.c3};
      psc_pkg::REG_C4: prdata = {16'h0000, coef_q.c4};
      psc_pkg::REG_C5: prdata = {16'h0000, coef_q.c5};
      psc_pkg::REG_C6: prdata = {16'h0000, coef_q.c6};
      default:         prdata = 32'h0000_0000;
    endcase
  end

  assign coef_o = coef_q;

endmodule

### hdl/psc_first_order.sv
// Stages 1..3: dT, coefficient products, first-order TEMP / OFF / SENS and T2
module psc_first_order (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [23:0]     d1_i,
  input  logic [23:0]     d2_i,
  input  psc_pkg::coef_t  coef_i,
  output logic            valid_o,
  output psc_pkg::first_t data_o
);

  logic [2:0] valid_q;

  // stage 1
  logic signed [psc_pkg::DtW-1:0] dt_d, dt_q;
  logic [23:0]                    d1_s1_q;

  // stage 2
  logic signed [41:0] p6_d, p6_q, p4_d, p4_q, p3_d, p3_q;
  logic signed [49:0] pdd_d, pdd_q;
  logic [23:0]        d1_s2_q;

  // stage 3
  logic signed [41:0] p6_adj, p4_adj, p3_adj, q6, q4, q3;
  psc_pkg::first_t    res_d, res_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // stage 1: dT = D2 - C5*2^8
  assign dt_d = $signed({1'b0, d2_i}) - $signed({1'b0, coef_i.c5, 8'h00});

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    d1_s1_q <= d1_i;
  end

  // stage 2: products of dT
  assign p6_d  = dt_q * $signed({1'b0, coef_i.c6});
  assign p4_d  = dt_q * $signed({1'b0, coef_i.c4});
  assign p3_d  = dt_q * $signed({1'b0, coef_i.c3});
  assign pdd_d = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    p6_q    <= p6_d;
    p4_q    <= p4_d;
    p3_q    <= p3_d;
    pdd_q   <= pdd_d;
    d1_s2_q <= d1_s1_q;
  end

  // stage 3: shifts that truncate toward zero, then offsets
  always_comb begin
    p6_adj = p6_q + (p6_q[41] ? 42'sd8388607 : 42'sd0);
    p4_adj = p4_q + (p4_q[41] ? 42'sd63 : 42'sd0);
    p3_adj = p3_q + (p3_q[41] ? 42'sd127 : 42'sd0);
    q6     = p6_adj >>> 23;
    q4     = p4_adj >>> 6;
    q3     = p3_adj >>> 7;

    res_d.d1   = d1_s2_q;
    res_d.temp = q6[psc_pkg::TempW-1:0] + psc_pkg::TempRef;
    res_d.off  = $signed({7'b0, coef_i.c2, 17'b0}) + q4[psc_pkg::OffW-1:0];
    res_d.sens = $signed({7'b0, coef_i.c1, 16'b0}) + q3[psc_pkg::SensW-1:0];
    // dT^2 is never negative, so the shift is already toward zero
    res_d.t2   = pdd_q[48:31];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q[2];
  assign data_o  = res_q;

endmodule

### hdl/psc_second_order.sv
// Stages 4..6: band select, second-order OFF2 / SENS2 / T2 and corrected terms
module psc_second_order (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  psc_pkg::first_t  data_i,
  output logic             valid_o,
  output psc_pkg::second_t data_o
);

  logic [2:0] valid_q;

  // stage 4
  logic signed [psc_pkg::TempW-1:0] a, b;
  logic signed [39:0]               aa_full, bb_full;
  logic [34:0]                      aa_q, bb_q;
  logic [1:0]                       band_d, band_s4_q;
  logic [psc_pkg::T2W-1:0]          t2_cold;
  logic signed [20:0]               tout_d, tout_q;
  logic [23:0]                      d1_s4_q;
  logic signed [psc_pkg::OffW-1:0]  off_s4_q;
  logic signed [psc_pkg::SensW-1:0] sens_s4_q;

  // stage 5
  logic [40:0]                      aa61;
  logic [38:0]                      bb15;
  logic [38:0]                      off2_d, off2_q;
  logic [37:0]                      sens2_d, sens2_q;
  logic signed [psc_pkg::ToutW-1:0] toutc_d, toutc_q;
  logic [1:0]                       band_s5_q;
  logic [23:0]                      d1_s5_q;
  logic signed [psc_pkg::OffW-1:0]  off_s5_q;
  logic signed [psc_pkg::SensW-1:0] sens_s5_q;

  // stage 6
  psc_pkg::second_t res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // stage 4: distances from the band limits, their squares, TEMP - T2
  assign a       = data_i.temp - psc_pkg::TempRef;
  assign b       = data_i.temp - psc_pkg::TempFrost;
  assign aa_full = a * a;
  assign bb_full = b * b;
  // T2 only applies below 20 degC
  assign t2_cold = (data_i.temp < psc_pkg::TempRef) ? data_i.t2 : '0;
  assign tout_d  = $signed({data_i.temp[psc_pkg::TempW-1], data_i.temp})
                 - $signed({3'b0, t2_cold});

  always_comb begin
    if (data_i.temp < psc_pkg::TempFrost) begin
      band_d = psc_pkg::BAND_FROST;
    end else if (data_i.temp < psc_pkg::TempRef) begin
      band_d = psc_pkg::BAND_COLD;
    end else begin
      band_d = psc_pkg::BAND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    aa_q      <= aa_full[34:0];
    bb_q      <= bb_full[34:0];
    band_s4_q <= band_d;
    tout_q    <= tout_d;
    d1_s4_q   <= data_i.d1;
    off_s4_q  <= data_i.off;
    sens_s4_q <= data_i.sens;
  end

  // stage 5: OFF2 and SENS2, temperature saturation
  assign aa61 = {6'b0, aa_q} * 41'd61;
  assign bb15 = {4'b0, bb_q} * 39'd15;

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    case (band_s4_q)
      psc_pkg::BAND_COLD: begin
        off2_d  = {2'b0, aa61[40:4]};
        sens2_d = {2'b0, aa_q, 1'b0};
      end
      psc_pkg::BAND_FROST: begin
        off2_d  = {2'b0, aa61[40:4]} + bb15;
        sens2_d = {2'b0, aa_q, 1'b0} + {bb_q, 3'b0};
      end
      default: ;
    endcase

    if (tout_q > 21'sd262143) begin
      toutc_d = psc_pkg::ToutMax;
    end else if (tout_q < -21'sd262144) begin
      toutc_d = psc_pkg::ToutMin;
    end else begin
      toutc_d = tout_q[psc_pkg::ToutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    off2_q    <= off2_d;
    sens2_q   <= sens2_d;
    toutc_q   <= toutc_d;
    band_s5_q <= band_s4_q;
    d1_s5_q   <= d1_s4_q;
    off_s5_q  <= off_s4_q;
    sens_s5_q <= sens_s4_q;
  end

  // stage 6: apply corrections
  always_comb begin
    res_d.d1   = d1_s5_q;
    res_d.off  = off_s5_q - $signed({1'b0, off2_q});
    res_d.sens = sens_s5_q - $signed({1'b0, sens2_q});
    res_d.tout = toutc_q;
    res_d.band = band_s5_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q[2];
  assign data_o  = res_q;

endmodule

### hdl/psc_pressure.sv
// Stages 7..11: D1*SENS in two partial products, scaling, offset, saturation
module psc_pressure (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  psc_pkg::second_t                 data_i,
  output logic                             valid_o,
  output logic signed [psc_pkg::ToutW-1:0] tout_o,
  output logic signed [psc_pkg::PresW-1:0] pres_o,
  output logic [1:0]                       band_o
);

  logic [4:0] valid_q;

  // side band carried along
  logic signed [psc_pkg::OffW-1:0]  off_q  [3];
  logic signed [psc_pkg::ToutW-1:0] tout_q [5];
  logic [1:0]                       band_q [5];

  // stage 7
  logic [43:0]        p_lo_d, p_lo_q;
  logic signed [43:0] p_hi_d, p_hi_q;

  // stage 8..11
  logic signed [62:0] prod_d, prod_q, prod_adj, q1_full;
  logic signed [41:0] q1_q;
  logic signed [42:0] diff_d, diff_q, diff_adj, q2;
  logic signed [psc_pkg::PresW-1:0] pres_d, pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  // side band shift line
  always_ff @(posedge clk_i) begin
    off_q[0]  <= data_i.off;
    tout_q[0] <= data_i.tout;
    band_q[0] <= data_i.band;
    for (int i = 1; i < 5; i++) begin
      tout_q[i] <= tout_q[i-1];
      band_q[i] <= band_q[i-1];
    end
    for (int i = 1; i < 3; i++) begin
      off_q[i] <= off_q[i-1];
    end
  end

  // stage 7: D1 times low and high halves of SENS
  assign p_lo_d = {20'b0, data_i.d1} * {24'b0, data_i.sens[19:0]};
  assign p_hi_d = $signed({1'b0, data_i.d1}) * $signed(data_i.sens[38:20]);

  always_ff @(posedge clk_i) begin
    p_lo_q <= p_lo_d;
    p_hi_q <= p_hi_d;
  end

  // stage 8: recombine partial products
  assign prod_d = $signed({p_hi_q[42:0], 20'b0}) + $signed({19'b0, p_lo_q});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // stage 9: /2^21 toward zero
  assign prod_adj = prod_q + (prod_q[62] ? 63'sd2097151 : 63'sd0);
  assign q1_full  = prod_adj >>> 21;

  always_ff @(posedge clk_i) begin
    q1_q <= q1_full[41:0];
  end

  // stage 10: subtract offset
  assign diff_d = $signed({q1_q[41], q1_q}) - $signed({{3{off_q[2][39]}}, off_q[2]});

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  // stage 11: /2^15 toward zero and saturate
  assign diff_adj = diff_q + (diff_q[42] ? 43'sd32767 : 43'sd0);
  assign q2       = diff_adj >>> 15;

  always_comb begin
    if (q2 > 43'sd67108863) begin
      pres_d = psc_pkg::PresMax;
    end else if (q2 < -43'sd67108864) begin
      pres_d = psc_pkg::PresMin;
    end else begin
      pres_d = q2[psc_pkg::PresW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pres_q <= pres_d;
  end

  assign valid_o = valid_q[4];
  assign pres_o  = pres_q;
  assign tout_o  = tout_q[4];
  assign band_o  = band_q[4];

endmodule

### hdl/pressure_sensor_compensation.sv
// Barometric sensor compensation, first and second order.
// Input: pulse start with raw_pressure_i (D1) and raw_temperature_i (D2);
// a transfer happens on any rising edge with start high and busy low.
// busy is always low, so a new sample may be issued every cycle.
// Output: result_valid_o is high for exactly one cycle with temperature
// (0.01 degC), pressure (0.01 mbar) and correction band; the receiver must
// take it in that cycle, it cannot stall the block.
// Throughput is one sample per cycle through the 11-stage pipeline
// (D1*SENS is split into two partial products over two stages).
// Calibration coefficients C1..C6 sit on the APB port at byte addresses
// 0x00..0x14; write them only while no sample is in flight.
// Reset clears the coefficients and every pipeline valid bit; samples in
// flight are dropped and no result is produced for them.
module pressure_sensor_compensation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [23:0]                      raw_pressure_i,
  input  logic [23:0]                      raw_temperature_i,
  output logic                             result_valid_o,
  output logic signed [psc_pkg::ToutW-1:0] temperature_centi_o,
  output logic signed [psc_pkg::PresW-1:0] pressure_centi_mbar_o,
  output logic [1:0]                       correction_band_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [psc_pkg::AddrW-1:0]        paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  psc_pkg::coef_t   coef;
  psc_pkg::first_t  first;
  psc_pkg::second_t second;
  logic             in_xfer, first_vld, second_vld;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // coefficient registers
  psc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  // first-order compensation
  psc_first_order u_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .d1_i    (raw_pressure_i),
    .d2_i    (raw_temperature_i),
    .coef_i  (coef),
    .valid_o (first_vld),
    .data_o  (first)
  );

  // second-order correction
  psc_second_order u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (first_vld),
    .data_i  (first),
    .valid_o (second_vld),
    .data_o  (second)
  );

  // pressure computation and output registers
  psc_pressure u_pressure (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (second_vld),
    .data_i  (second),
    .valid_o (result_valid_o),
    .tout_o  (temperature_centi_o),
    .pres_o  (pressure_centi_mbar_o),
    .band_o  (correction_band_o)
  );

endmodule

### hdl/psc_checker.sv
// Port-level checks on the compensation block
module psc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             result_valid_o,
  input logic signed [psc_pkg::ToutW-1:0] temperature_centi_o,
  input logic [1:0]                       correction_band_o
);

  // every accepted sample yields a result after the pipeline latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(psc_pkg::PipeLatency) result_valid_o)
    else $error("accepted sample produced no result");

  // no result without a sample accepted one latency earlier
  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, psc_pkg::PipeLatency))
    else $error("result without matching sample");

  // band code stays within its three meanings
  a_band_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (correction_band_o == psc_pkg::BAND_NONE ||
                        correction_band_o == psc_pkg::BAND_COLD ||
                        correction_band_o == psc_pkg::BAND_FROST))
    else $error("bad correction band code");

  // no correction means a warm reading without T2
  a_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && correction_band_o == psc_pkg::BAND_NONE)
      |-> (temperature_centi_o >= psc_pkg::ToutRef))
    else $error("warm band with low temperature");

  // frost band means TEMP below -15 degC, T2 only lowers it
  a_frost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && correction_band_o == psc_pkg::BAND_FROST)
      |-> (temperature_centi_o < psc_pkg::ToutFrost))
    else $error("frost band with high temperature");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start               (start),
  .busy                (busy),
  .result_valid_o      (result_valid_o),
  .temperature_centi_o (temperature_centi_o),
  .correction_band_o   (correction_band_o)
);
